FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the convolution unit RTL.
// Each macro checks a property on the rising edge of clk, off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every checked clock edge.
`define CDF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The condition must never be true at a checked clock edge.
`define CDF_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/cdf_pkg.sv
// Shared types and constants for the direct 2D convolution unit.
// Used by cdf_mac and conv2d_direct_forward_unit; depends on nothing.
package cdf_pkg;

	// Input word operation codes.
	localparam logic [1:0] OP_LOAD_WEIGHT = 2'd0;
	localparam logic [1:0] OP_LOAD_BIAS   = 2'd1;
	localparam logic [1:0] OP_LOAD_PIXEL  = 2'd2;
	localparam logic [1:0] OP_COMPUTE     = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SAT     = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] CFG_IN_CH   = 3'd0;
	localparam logic [2:0] CFG_OUT_CH  = 3'd1;
	localparam logic [2:0] CFG_KERNEL  = 3'd2;
	localparam logic [2:0] CFG_STEP    = 3'd3;
	localparam logic [2:0] CFG_PAD     = 3'd4;
	localparam logic [2:0] CFG_HEIGHT  = 3'd5;
	localparam logic [2:0] CFG_WIDTH   = 3'd6;

	localparam int MAX_STEP = 4;

	// Shared multiplier operand width and accumulator width.
	localparam int MUL_W = 24;
	localparam int ACC_W = 48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} seq_state_t;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic load_bias;
		logic acc_en;
	} mac_ctl_t;

endpackage

FILE: rtl/core/cdf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the weight, bias and image stores.
module cdf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/cdf_mac.sv
// Shared multiplier with product register, wide accumulator and saturation.
// Depends on cdf_pkg; driven by the sequencer in conv2d_direct_forward_unit.
module cdf_mac import cdf_pkg::*; (
	input  logic                      clk,
	input  mac_ctl_t                  ctl,
	input  logic signed [MUL_W-1:0]   op_a,
	input  logic signed [MUL_W-1:0]   op_b,
	input  logic signed [15:0]        bias,
	output logic signed [2*MUL_W-1:0] prod,
	output logic signed [31:0]        sum,
	output logic                      saturated
);

	logic signed [2*MUL_W-1:0] prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic                      hi_over;
	logic                      lo_over;

	// One product per cycle, registered before it is used.
	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	// The bias in Q8.8, shifted into Q16.16, starts the sum; valid products add to it.
	always_ff @(posedge clk) begin
		if (ctl.load_bias) begin
			acc_q <= ACC_W'(bias) <<< 8;
		end else if (ctl.acc_en) begin
			acc_q <= acc_q + ACC_W'(prod_q);
		end
	end

	// Clamp to the signed 32-bit range.
	always_comb begin
		hi_over   = acc_q > ACC_W'(signed'(32'sh7fffffff));
		lo_over   = acc_q < ACC_W'(signed'(32'sh80000000));
		saturated = hi_over || lo_over;
		if (hi_over) begin
			sum = 32'sh7fffffff;
		end else if (lo_over) begin
			sum = 32'sh80000000;
		end else begin
			sum = acc_q[31:0];
		end
	end

	assign prod = prod_q;

endmodule

FILE: rtl/core/conv2d_direct_forward_unit.sv
// Top level of the direct 2D convolution unit: ports, registers, stores, sequencer.
// Depends on cdf_pkg, cdf_ram, cdf_mac and assert_macros.svh.
//
//  channel  | direction | content
//  s_*      | in        | load or compute word; tuser = operation
//  m_*      | out       | one result word per compute; tuser = status
//  cfg_*    | in        | register write, no read-back
//
// A load word writes at most one store entry. A compute word runs the setup products,
// then one multiply per tap (in_channel_count * kernel_side^2, 784 at most), a drain
// of the product pipeline, then posts the result; the single multiplier is shared.
// A position outside the output map skips the tap loop. s_tready is low during
// a compute and while a finished result waits in a full output register.
// Reset loads register defaults; store contents stay undefined until written.
`include "assert_macros.svh"
module conv2d_direct_forward_unit import cdf_pkg::*; #(
	parameter int MAX_IN_CHANNELS  = 16,
	parameter int MAX_OUT_CHANNELS = 16,
	parameter int MAX_KERNEL       = 7,
	parameter int MAX_HEIGHT       = 32,
	parameter int MAX_WIDTH        = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// store_index[13:0], load_value[29:14], target_channel[33:30],
	// target_row[39:34], target_col[45:40], zero pad [47:46]
	input  logic [47:0] s_tdata,
	// operation[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// result_value[31:0], result_channel[35:32], result_row[41:36],
	// result_col[47:42]
	output logic [47:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	localparam int W_DEPTH = MAX_OUT_CHANNELS * MAX_IN_CHANNELS * MAX_KERNEL * MAX_KERNEL;
	localparam int B_DEPTH = MAX_OUT_CHANNELS;
	localparam int I_DEPTH = MAX_IN_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
	localparam int WAW     = W_DEPTH > 1 ? $clog2(W_DEPTH) : 1;
	localparam int BAW     = B_DEPTH > 1 ? $clog2(B_DEPTH) : 1;
	localparam int IAW     = I_DEPTH > 1 ? $clog2(I_DEPTH) : 1;
	localparam int RB_W    = IAW + 3;

	// Configuration registers.
	logic [4:0] in_ch_q, out_ch_q;
	logic [2:0] kernel_q, step_q;
	logic [1:0] pad_q;
	logic [5:0] height_q, width_q;

	// Sequencer state.
	seq_state_t state_q, state_d;
	logic [2:0] setup_q;
	logic [1:0] drain_q;
	logic       outside_q;
	logic       v1_q, v2_q;

	// Request and setup products.
	logic [3:0]  oc_q;
	logic [5:0]  orow_q, ocol_q;
	logic [7:0]  rs_q, cs_q;
	logic [IAW:0] hw_q;
	logic [WAW-1:0] wbase_q;
	logic signed [RB_W-1:0] rowstart_q;

	// Tap walk.
	logic [4:0] ic_q;
	logic [2:0] kh_q, kw_q;
	logic signed [9:0] ih_q, iw_q;
	logic signed [RB_W-1:0] row_base_q;
	logic [IAW:0] chan_base_q;
	logic [WAW-1:0] wi_q;

	logic signed [9:0] ih0, iw0;
	logic [6:0] ph, pw;
	logic       in_map;
	logic       tap_ok;
	logic       last_tap;
	logic [IAW-1:0] pi;

	logic s_acc, m_acc, out_free;
	logic [1:0] op;
	logic [13:0] st_index;
	logic [15:0] ld_value;

	logic [15:0] w_rdata, b_rdata, i_rdata;
	mac_ctl_t mac_ctl;
	logic signed [MUL_W-1:0] op_a, op_b;
	logic signed [2*MUL_W-1:0] prod;
	logic signed [31:0] sum;
	logic saturated;

	assign op       = s_tuser;
	assign st_index = s_tdata[13:0];
	assign ld_value = s_tdata[29:14];
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;
	assign out_free = !m_tvalid || m_tready;

	// Configuration writes; all but the padding are clamped to their range.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= 5'd1;
			out_ch_q <= 5'd1;
			kernel_q <= 3'd3;
			step_q   <= 3'd1;
			pad_q    <= 2'd0;
			height_q <= 6'd32;
			width_q  <= 6'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IN_CH: begin
					if (cfg_data[4:0] == 5'd0) in_ch_q <= 5'd1;
					else if (32'(cfg_data[4:0]) > MAX_IN_CHANNELS) in_ch_q <= 5'(MAX_IN_CHANNELS);
					else in_ch_q <= cfg_data[4:0];
				end
				CFG_OUT_CH: begin
					if (cfg_data[4:0] == 5'd0) out_ch_q <= 5'd1;
					else if (32'(cfg_data[4:0]) > MAX_OUT_CHANNELS) out_ch_q <= 5'(MAX_OUT_CHANNELS);
					else out_ch_q <= cfg_data[4:0];
				end
				CFG_KERNEL: begin
					if (cfg_data[2:0] == 3'd0) kernel_q <= 3'd1;
					else if (32'(cfg_data[2:0]) > MAX_KERNEL) kernel_q <= 3'(MAX_KERNEL);
					else kernel_q <= cfg_data[2:0];
				end
				CFG_STEP: begin
					if (cfg_data[2:0] == 3'd0) step_q <= 3'd1;
					else if (32'(cfg_data[2:0]) > MAX_STEP) step_q <= 3'(MAX_STEP);
					else step_q <= cfg_data[2:0];
				end
				CFG_PAD: pad_q <= cfg_data[1:0];
				CFG_HEIGHT: begin
					if (cfg_data == 6'd0) height_q <= 6'd1;
					else if (32'(cfg_data) > MAX_HEIGHT) height_q <= 6'(MAX_HEIGHT);
					else height_q <= cfg_data;
				end
				CFG_WIDTH: begin
					if (cfg_data == 6'd0) width_q <= 6'd1;
					else if (32'(cfg_data) > MAX_WIDTH) width_q <= 6'(MAX_WIDTH);
					else width_q <= cfg_data;
				end
				default: ;
			endcase
		end
	end

	// Tap bounds, output-map check, last-tap flag and image address of the current tap.
	always_comb begin
		ih0    = signed'({2'b00, rs_q}) - signed'({8'b0, pad_q});
		iw0    = signed'({2'b00, cs_q}) - signed'({8'b0, pad_q});
		ph     = {1'b0, height_q} + {4'b0, pad_q, 1'b0};
		pw     = {1'b0, width_q} + {4'b0, pad_q, 1'b0};
		in_map = ({1'b0, oc_q} < out_ch_q) && (ph >= {4'b0, kernel_q})
			&& (pw >= {4'b0, kernel_q})
			&& ({1'b0, rs_q} <= ({2'b0, ph} - {6'b0, kernel_q}))
			&& ({1'b0, cs_q} <= ({2'b0, pw} - {6'b0, kernel_q}));
		tap_ok = (ih_q >= 10'sd0) && (ih_q < signed'({4'b0, height_q}))
			&& (iw_q >= 10'sd0) && (iw_q < signed'({4'b0, width_q}));
		pi       = IAW'(row_base_q + RB_W'(iw_q));
		last_tap = (kw_q == kernel_q - 3'd1) && (kh_q == kernel_q - 3'd1)
			&& (ic_q == in_ch_q - 5'd1);
	end

	// Operand select for the shared multiplier.
	always_comb begin
		op_a = '0;
		op_b = '0;
		if (state_q == ST_SETUP) begin
			case (setup_q)
				3'd0: begin op_a = MUL_W'(orow_q); op_b = MUL_W'(step_q); end
				3'd1: begin op_a = MUL_W'(ocol_q); op_b = MUL_W'(step_q); end
				3'd2: begin op_a = MUL_W'(height_q); op_b = MUL_W'(width_q); end
				3'd3: begin op_a = MUL_W'(oc_q); op_b = MUL_W'(in_ch_q); end
				3'd4, 3'd5: begin op_a = MUL_W'(prod); op_b = MUL_W'(kernel_q); end
				3'd6: begin op_a = MUL_W'(ih0); op_b = MUL_W'(width_q); end
				default: ;
			endcase
		end else begin
			op_a = MUL_W'(signed'(i_rdata));
			op_b = MUL_W'(signed'(w_rdata));
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Next state and MAC control.
	always_comb begin
		state_d           = state_q;
		mac_ctl.load_bias = 1'b0;
		mac_ctl.acc_en    = v2_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc && op == OP_COMPUTE) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (setup_q == 3'd7) begin
					mac_ctl.load_bias = 1'b1;
					state_d = in_map ? ST_RUN : ST_FINISH;
				end
			end
			ST_RUN: begin
				if (last_tap) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (drain_q == 2'd1) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer counters and product pipeline flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q   <= '0;
			drain_q   <= '0;
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			outside_q <= 1'b0;
		end else begin
			v1_q <= (state_q == ST_RUN) && tap_ok;
			v2_q <= v1_q;
			setup_q <= (state_q == ST_SETUP) ? setup_q + 3'd1 : 3'd0;
			drain_q <= (state_q == ST_DRAIN) ? drain_q + 2'd1 : 2'd0;
			if (state_q == ST_SETUP && setup_q == 3'd7) outside_q <= !in_map;
		end
	end

	// Request capture, setup products and the tap walk.
	always_ff @(posedge clk) begin
		if (s_acc && op == OP_COMPUTE) begin
			oc_q   <= s_tdata[33:30];
			orow_q <= s_tdata[39:34];
			ocol_q <= s_tdata[45:40];
		end
		if (state_q == ST_SETUP) begin
			case (setup_q)
				3'd1: rs_q <= 8'(prod);
				3'd2: cs_q <= 8'(prod);
				3'd3: hw_q <= (IAW+1)'(prod);
				3'd6: wbase_q <= WAW'(prod);
				3'd7: begin
					rowstart_q  <= RB_W'(prod);
					row_base_q  <= RB_W'(prod);
					chan_base_q <= '0;
					wi_q        <= wbase_q;
					ic_q        <= '0;
					kh_q        <= '0;
					kw_q        <= '0;
					ih_q        <= ih0;
					iw_q        <= iw0;
				end
				default: ;
			endcase
		end else if (state_q == ST_RUN) begin
			wi_q <= wi_q + WAW'(1);
			if (kw_q != kernel_q - 3'd1) begin
				kw_q <= kw_q + 3'd1;
				iw_q <= iw_q + 10'sd1;
			end else begin
				kw_q <= '0;
				iw_q <= iw0;
				if (kh_q != kernel_q - 3'd1) begin
					kh_q       <= kh_q + 3'd1;
					ih_q       <= ih_q + 10'sd1;
					row_base_q <= row_base_q + RB_W'(width_q);
				end else begin
					kh_q        <= '0;
					ih_q        <= ih0;
					ic_q        <= ic_q + 5'd1;
					chan_base_q <= chan_base_q + hw_q;
					row_base_q  <= RB_W'(chan_base_q + hw_q) + rowstart_q;
				end
			end
		end
	end

	// Output register; a finished result waits here until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_acc) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			m_tdata <= {ocol_q, orow_q, oc_q, outside_q ? 32'd0 : 32'(sum)};
			m_tuser <= outside_q ? ST_OUTSIDE : (saturated ? ST_SAT : ST_OK);
		end
	end

	// Stores.
	cdf_ram #(.WIDTH(16), .DEPTH(W_DEPTH)) u_weight_ram (
		.clk   (clk),
		.we    (s_acc && op == OP_LOAD_WEIGHT && 32'(st_index) < W_DEPTH),
		.waddr (WAW'(st_index)),
		.wdata (ld_value),
		.raddr (wi_q),
		.rdata (w_rdata)
	);

	cdf_ram #(.WIDTH(16), .DEPTH(B_DEPTH)) u_bias_ram (
		.clk   (clk),
		.we    (s_acc && op == OP_LOAD_BIAS && 32'(st_index) < B_DEPTH),
		.waddr (BAW'(st_index)),
		.wdata (ld_value),
		.raddr (BAW'(oc_q)),
		.rdata (b_rdata)
	);

	cdf_ram #(.WIDTH(16), .DEPTH(I_DEPTH)) u_image_ram (
		.clk   (clk),
		.we    (s_acc && op == OP_LOAD_PIXEL && 32'(st_index) < I_DEPTH),
		.waddr (IAW'(st_index)),
		.wdata (ld_value),
		.raddr (pi),
		.rdata (i_rdata)
	);

	cdf_mac u_mac (
		.clk       (clk),
		.ctl       (mac_ctl),
		.op_a      (op_a),
		.op_b      (op_b),
		.bias      (signed'(b_rdata)),
		.prod      (prod),
		.sum       (sum),
		.saturated (saturated)
	);

	// A result outside the output map carries a zero value.
	`CDF_ASSERT(a_outside_zero, (m_tvalid && m_tuser == ST_OUTSIDE) |-> (m_tdata[31:0] == 32'd0), "outside result not zero")
	// A saturated result sits on one of the two bounds.
	`CDF_ASSERT(a_sat_bound, (m_tvalid && m_tuser == ST_SAT) |-> (m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000), "saturated value off bound")
	// Accepting a compute word closes the input.
	`CDF_NEVER(a_busy_after_compute, $past(s_acc && op == OP_COMPUTE) && s_tready, "input open during compute")

endmodule
